// File: rtl/gfmd_pkg.sv
// ----------------------------------------------------------------------------
// gfmd_pkg
// Types, constants and the neighbour step function shared by the grid flood distance block.
// ----------------------------------------------------------------------------
package gfmd_pkg;

  localparam int REG_W  = 8;
  localparam int LOAD_W = 15;
  localparam int DIST_W = 14;
  localparam logic [DIST_W-1:0] DIST_MAX = 14'h3FFF;

  typedef enum logic [1:0] {
    CFG_WIDTH   = 2'd0,
    CFG_HEIGHT  = 2'd1,
    CFG_START_X = 2'd2,
    CFG_START_Y = 2'd3
  } cfg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_CLEAR,
    ST_CLEAR_END,
    ST_POP,
    ST_POP_WAIT,
    ST_NB_READ,
    ST_NB_EVAL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic row_dec;
    logic row_inc;
    logic col_dec;
    logic col_inc;
  } nb_step_t;

  function automatic nb_step_t nb_step(input logic [2:0] nb);
    nb_step_t s;
    s = '0;
    case (nb)
      3'd0: begin s.row_dec = 1'b1; s.col_dec = 1'b1; end
      3'd1: begin s.row_dec = 1'b1; end
      3'd2: begin s.row_dec = 1'b1; s.col_inc = 1'b1; end
      3'd3: begin s.col_dec = 1'b1; end
      3'd4: begin s.col_inc = 1'b1; end
      3'd5: begin s.row_inc = 1'b1; s.col_dec = 1'b1; end
      3'd6: begin s.row_inc = 1'b1; end
      3'd7: begin s.row_inc = 1'b1; s.col_inc = 1'b1; end
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

// File: rtl/grid_flood_max_distance_top.sv
// ----------------------------------------------------------------------------
// grid_flood_max_distance_top
// Loads a grid of open and blocked cells and floods it breadth first from
// the start cell with 8-neighbour moves, reporting the largest distance.
// ----------------------------------------------------------------------------
// Each cell is taken in one cycle while busy is low. After the last cell of
// the grid, if the start cell is in it, the block stays busy for the flood:
// a clearing pass over the whole cell memory (MAX_SIDE rounded up to a
// power of two per side), then for every reached cell a queue pop and a
// read and evaluation of each of its eight neighbours inside the grid, all
// through the single read port of the cell memory. The result then appears
// with done for exactly one cycle and cannot be held off. Writing the width
// register while idle makes it busy while the load position is recomputed.
module grid_flood_max_distance_top
  import gfmd_pkg::*;
#(
  parameter int MAX_SIDE = 128
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic                  cell_open,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [REG_W-1:0]      cfg_data,
  output logic                  done,
  output logic [DIST_W-1:0]     max_distance
);

  localparam int CW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int AW    = 2 * CW;
  localparam int DEPTH = 1 << AW;
  localparam int PW    = AW + 1;
  localparam int XW    = (CW + 1 > 9) ? CW + 1 : 9;

  function automatic logic [REG_W-1:0] side_of(input logic [REG_W-1:0] v);
    if (v == '0) begin
      return REG_W'(1);
    end
    if (XW'(v) > XW'(MAX_SIDE)) begin
      return REG_W'(MAX_SIDE);
    end
    return v;
  endfunction

  state_t state, state_next;

  logic [REG_W-1:0] grid_width, grid_height, start_x, start_y;
  logic [REG_W-1:0] w_c, h_c;
  logic [LOAD_W-1:0] load_count, load_next;
  logic [LOAD_W-1:0] row;
  logic [REG_W-1:0]  col;
  logic              accept, run_end, width_wr, start_ok;
  logic [2*REG_W-1:0] cell_total;

  logic [LOAD_W-1:0] div_q, div_q_next;
  logic [REG_W-1:0]  div_rem, div_rem_next;
  logic [REG_W:0]    div_sh;
  logic              div_ge;
  logic [3:0]        div_cnt;

  logic [1:0]    cell_mem [DEPTH];
  logic [AW-1:0] q_mem [DEPTH];
  logic [1:0]    cell_rd;
  logic [AW-1:0] q_rd;
  logic          cell_we;
  logic [AW-1:0] cell_waddr, cell_raddr;
  logic [1:0]    cell_wdata;
  logic          q_we;
  logic [AW-1:0] q_waddr, q_wdata;

  logic [AW-1:0] sweep, clr_addr, start_addr, load_addr;
  logic          clr_pend;
  logic [PW-1:0] head, tail, level_end;
  logic [PW-1:0] level_dist;
  logic [AW-1:0] cur;
  logic [2:0]    nb;
  nb_step_t      step;
  logic [XW-1:0] nb_row, nb_col;
  logic          nb_ok, push;
  logic [AW-1:0] nb_addr;
  logic [DIST_W-1:0] dist_sat;

  assign w_c        = side_of(grid_width);
  assign h_c        = side_of(grid_height);
  assign accept     = start && (state == ST_IDLE);
  assign load_next  = load_count + LOAD_W'(1);
  assign cell_total = w_c * h_c;
  assign run_end    = ((2*REG_W)'(load_next) >= cell_total) || (load_next == '0);
  assign width_wr   = cfg_we && (cfg_index == CFG_WIDTH);
  assign start_ok   = (start_x != '0) && (start_x <= w_c) &&
                      (start_y != '0) && (start_y <= h_c);
  assign start_addr = {CW'(h_c - start_y), CW'(start_x - REG_W'(1))};
  assign load_addr  = {CW'(row), CW'(col)};

  assign div_sh       = {div_rem, div_q[LOAD_W-1]};
  assign div_ge       = div_sh >= {1'b0, w_c};
  assign div_rem_next = div_ge ? REG_W'(div_sh - {1'b0, w_c}) : REG_W'(div_sh);
  assign div_q_next   = {div_q[LOAD_W-2:0], div_ge};

  assign step    = nb_step(nb);
  assign nb_row  = step.row_dec ? XW'(cur[AW-1:CW]) - XW'(1) :
                   step.row_inc ? XW'(cur[AW-1:CW]) + XW'(1) : XW'(cur[AW-1:CW]);
  assign nb_col  = step.col_dec ? XW'(cur[CW-1:0]) - XW'(1) :
                   step.col_inc ? XW'(cur[CW-1:0]) + XW'(1) : XW'(cur[CW-1:0]);
  assign nb_ok   = !(step.row_dec && (cur[AW-1:CW] == '0)) &&
                   !(step.col_dec && (cur[CW-1:0] == '0)) &&
                   (nb_row < XW'(h_c)) && (nb_col < XW'(w_c));
  assign nb_addr = {CW'(nb_row), CW'(nb_col)};
  assign push    = (state == ST_NB_EVAL) && cell_rd[1] && !cell_rd[0];

  assign dist_sat = (32'(level_dist) > 32'(DIST_MAX)) ? DIST_MAX : DIST_W'(level_dist);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && run_end) begin
          state_next = start_ok ? ST_CLEAR : ST_DONE;
        end else if (width_wr) begin
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (div_cnt == 4'(LOAD_W - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        if (sweep == '1) begin
          state_next = ST_CLEAR_END;
        end
      end
      ST_CLEAR_END: state_next = ST_POP;
      ST_POP:       state_next = (head == tail) ? ST_DONE : ST_POP_WAIT;
      ST_POP_WAIT:  state_next = ST_NB_READ;
      ST_NB_READ: begin
        if (nb_ok) begin
          state_next = ST_NB_EVAL;
        end else if (nb == 3'd7) begin
          state_next = ST_POP;
        end
      end
      ST_NB_EVAL:   state_next = (nb == 3'd7) ? ST_POP : ST_NB_READ;
      ST_DONE:      state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy       = (state != ST_IDLE);
    done       = (state == ST_DONE);
    cell_we    = 1'b0;
    cell_waddr = load_addr;
    cell_wdata = {cell_open, 1'b0};
    cell_raddr = (state == ST_CLEAR) ? sweep : nb_addr;
    q_we       = 1'b0;
    q_waddr    = tail[AW-1:0];
    q_wdata    = nb_addr;
    if (accept && (row < LOAD_W'(MAX_SIDE))) begin
      cell_we = 1'b1;
    end else if (clr_pend) begin
      cell_we    = 1'b1;
      cell_waddr = clr_addr;
      cell_wdata = {cell_rd[1], clr_addr == start_addr};
    end else if (push) begin
      cell_we    = 1'b1;
      cell_waddr = nb_addr;
      cell_wdata = 2'b11;
    end
    if (state == ST_CLEAR_END) begin
      q_we    = 1'b1;
      q_waddr = '0;
      q_wdata = start_addr;
    end else if (push) begin
      q_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cell_we) begin
      cell_mem[cell_waddr] <= cell_wdata;
    end
    cell_rd <= cell_mem[cell_raddr];
    if (q_we) begin
      q_mem[q_waddr] <= q_wdata;
    end
    q_rd <= q_mem[head[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      grid_width   <= REG_W'(128);
      grid_height  <= REG_W'(128);
      start_x      <= REG_W'(1);
      start_y      <= REG_W'(1);
      load_count   <= '0;
      row          <= '0;
      col          <= '0;
      max_distance <= '0;
      clr_pend     <= 1'b0;
      sweep        <= '0;
      head         <= '0;
      tail         <= '0;
      level_end    <= '0;
      level_dist   <= '0;
      nb           <= '0;
      div_cnt      <= '0;
    end else begin
      state    <= state_next;
      clr_pend <= (state == ST_CLEAR);
      clr_addr <= sweep;
      if (cfg_we) begin
        case (cfg_index)
          CFG_WIDTH:   grid_width  <= cfg_data;
          CFG_HEIGHT:  grid_height <= cfg_data;
          CFG_START_X: start_x     <= cfg_data;
          CFG_START_Y: start_y     <= cfg_data;
          default:     grid_width  <= grid_width;
        endcase
      end
      case (state)
        ST_IDLE: begin
          sweep <= '0;
          if (accept) begin
            if (run_end) begin
              load_count   <= '0;
              row          <= '0;
              col          <= '0;
              max_distance <= '0;
            end else begin
              load_count <= load_next;
              if (col + REG_W'(1) == w_c) begin
                col <= '0;
                row <= row + LOAD_W'(1);
              end else begin
                col <= col + REG_W'(1);
              end
            end
          end
          if (width_wr && !(accept && run_end)) begin
            div_q   <= accept ? load_next : load_count;
            div_rem <= '0;
            div_cnt <= '0;
          end
        end
        ST_DIVIDE: begin
          div_q   <= div_q_next;
          div_rem <= div_rem_next;
          div_cnt <= div_cnt + 4'd1;
          if (div_cnt == 4'(LOAD_W - 1)) begin
            row <= div_q_next;
            col <= div_rem_next;
          end
        end
        ST_CLEAR: sweep <= sweep + AW'(1);
        ST_CLEAR_END: begin
          head       <= '0;
          tail       <= PW'(1);
          level_end  <= PW'(1);
          level_dist <= '0;
        end
        ST_POP: begin
          if (head == tail) begin
            max_distance <= dist_sat;
          end else begin
            head <= head + PW'(1);
            if (head == level_end) begin
              level_dist <= level_dist + PW'(1);
              level_end  <= tail;
            end
          end
        end
        ST_POP_WAIT: begin
          cur <= q_rd;
          nb  <= '0;
        end
        ST_NB_READ: begin
          if (!nb_ok) begin
            nb <= nb + 3'd1;
          end
        end
        ST_NB_EVAL: begin
          nb <= nb + 3'd1;
          if (push) begin
            tail <= tail + PW'(1);
          end
        end
        default: sweep <= sweep;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for more than one cycle");
  a_queue_order: assert property (@(posedge clk) disable iff (rst) head <= tail)
    else $error("frontier queue read ran past its write pointer");
  a_col_in_row: assert property (@(posedge clk) disable iff (rst)
      (state == ST_IDLE) |-> (col < w_c))
    else $error("load column outside the configured width");
`endif

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for grid_flood_max_distance_top. Grids of open and blocked cells
// of many shapes are loaded one cell per transfer with random gaps. A local
// breadth-first flood predicts each max_distance, which is checked when done
// pulses.
// ----------------------------------------------------------------------------
module tb_top;
  import gfmd_pkg::*;

  localparam int SIDE  = 128;
  localparam int CELLS = SIDE * SIDE;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  cell_open = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [1:0]            cfg_index = CFG_WIDTH;
  logic [REG_W-1:0]      cfg_data = '0;
  logic                  done;
  logic [DIST_W-1:0]     max_distance;

  grid_flood_max_distance_top #(.MAX_SIDE(SIDE)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cell_open(cell_open),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .max_distance(max_distance)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bit               cell_q[$];
  logic [DIST_W-1:0] distance_q[$];
  int               gap_left = 0;
  bit               calm = 1'b0;
  int               err_count = 0;
  int               cell_total = 0;

  int  grid_w_reg = 128, grid_h_reg = 128, start_x_reg = 1, start_y_reg = 1;
  bit  open_cells[CELLS];
  int  reach_dist[CELLS];
  int  frontier[CELLS];
  int  load_pos = 0;

  function automatic int clamp_side(int v);
    if (v == 0) return 1;
    if (v > SIDE) return SIDE;
    return v;
  endfunction

  function automatic int flood_depth(int w, int h);
    int head, tail, best, cur, r, c, d, nr, nc, idx;
    head = 0;
    tail = 0;
    best = 0;
    foreach (reach_dist[i]) reach_dist[i] = 0;
    if (start_x_reg == 0 || start_x_reg > w || start_y_reg == 0 || start_y_reg > h)
      return 0;
    idx = (h - start_y_reg) * SIDE + start_x_reg - 1;
    reach_dist[idx] = 1;
    frontier[tail++] = idx;
    while (head < tail) begin
      cur = frontier[head++];
      r = cur / SIDE;
      c = cur % SIDE;
      d = reach_dist[cur];
      if (d - 1 > best) best = d - 1;
      for (int dr = -1; dr <= 1; dr++) begin
        for (int dc = -1; dc <= 1; dc++) begin
          nr = r + dr;
          nc = c + dc;
          if ((dr == 0 && dc == 0) || nr < 0 || nc < 0 || nr >= h || nc >= w) continue;
          idx = nr * SIDE + nc;
          if (!open_cells[idx] || reach_dist[idx] != 0) continue;
          reach_dist[idx] = d + 1;
          if (tail < CELLS) frontier[tail++] = idx;
        end
      end
    end
    return (best > int'(DIST_MAX)) ? int'(DIST_MAX) : best;
  endfunction

  function automatic void take_cell(bit v);
    int w, h, row, col;
    w = clamp_side(grid_w_reg);
    h = clamp_side(grid_h_reg);
    row = load_pos / w;
    col = load_pos % w;
    if (row < SIDE) open_cells[row * SIDE + col] = v;
    load_pos = (load_pos + 1) & 'h7FFF;
    if (load_pos >= w * h || load_pos == 0) begin
      load_pos = 0;
      distance_q.push_back(DIST_W'(flood_depth(w, h)));
    end
  endfunction

  function automatic int pick_gap();
    int p;
    if (calm) return 0;
    p = $urandom_range(99);
    if (p < 65) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_left <= 0;
    end else begin
      if (start && !busy) take_cell(cell_open);
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start <= 1'b0;
        end else if (cell_q.size() > 0) begin
          start <= 1'b1;
          cell_open <= cell_q.pop_front();
          gap_left <= pick_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      if (distance_q.size() == 0) begin
        $error("unexpected result: max_distance actual %0d", max_distance);
        err_count++;
      end else begin
        if (max_distance !== distance_q[0]) begin
          $error("max_distance mismatch: expected %0d actual %0d",
                 distance_q[0], max_distance);
          err_count++;
        end
        void'(distance_q.pop_front());
      end
    end
  end

  task automatic reg_write(cfg_index_t idx, int val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= REG_W'(val);
    case (idx)
      CFG_WIDTH:   grid_w_reg = val;
      CFG_HEIGHT:  grid_h_reg = val;
      CFG_START_X: start_x_reg = val;
      default:     start_y_reg = val;
    endcase
  endtask

  task automatic wait_idle();
    while (cell_q.size() != 0 || start || distance_q.size() != 0) @(negedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic run_grid(int w, int h, int sx, int sy, int open_pct);
    int n;
    wait_idle();
    reg_write(CFG_WIDTH, w);
    reg_write(CFG_HEIGHT, h);
    reg_write(CFG_START_X, sx);
    reg_write(CFG_START_Y, sy);
    @(posedge clk);
    cfg_we <= 1'b0;
    calm = ($urandom_range(3) == 0);
    n = clamp_side(w) * clamp_side(h);
    for (int i = 0; i < n; i++) cell_q.push_back($urandom_range(99) < open_pct);
    cell_total += n;
  endtask

  initial begin
    int w, h, sx, sy;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    run_grid(1, 1, 1, 1, 100);
    run_grid(1, 1, 1, 1, 0);
    run_grid(3, 3, 2, 2, 100);
    run_grid(2, 2, 2, 1, 0);
    run_grid(4, 3, 0, 1, 100);
    run_grid(4, 3, 5, 1, 100);
    run_grid(4, 3, 2, 0, 100);
    run_grid(4, 3, 2, 4, 100);
    run_grid(0, 3, 1, 3, 100);
    run_grid(5, 0, 5, 1, 100);
    run_grid(255, 1, 128, 1, 100);
    run_grid(1, 128, 1, 128, 100);
    run_grid(6, 5, 3, 3, 60);
    while (cell_total < 1900) begin
      w = $urandom_range(1, 12);
      h = $urandom_range(1, 12);
      sx = $urandom_range(1, w);
      sy = $urandom_range(1, h);
      if ($urandom_range(9) == 0) sx = $urandom_range(1) ? 0 : $urandom_range(w + 1, 255);
      if ($urandom_range(9) == 0) sy = $urandom_range(1) ? 0 : $urandom_range(h + 1, 255);
      run_grid(w, h, sx, sy, $urandom_range(50, 100));
    end
    wait_idle();
    repeat (50) @(posedge clk);
    if (err_count == 0) begin
      $display("PASS grid_flood_max_distance_top");
    end else begin
      $display("FAIL grid_flood_max_distance_top");
    end
    $finish;
  end

  initial begin
    #1500000000;
    $display("FAIL grid_flood_max_distance_top");
    $finish;
  end

endmodule
